// ----- hdl/qps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qps_pkg
// shared types and constants of the queue-proportional sampling scheduler
// ----------------------------------------------------------------------------
package qps_pkg;

  localparam int NUM_PORTS      = 16;
  localparam int PORT_W         = 4;
  localparam int COUNT_WIDTH    = 16;
  localparam int MAX_ITERATIONS = 8;
  localparam int TOTAL_W        = COUNT_WIDTH + PORT_W;
  localparam logic [31:0] LFSR_MASK = 32'h8020_0003;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  localparam logic [1:0] POL_LONGEST  = 2'd0;
  localparam logic [1:0] POL_EARLIEST = 2'd1;
  localparam logic [1:0] POL_SHORTEST = 2'd2;
  localparam logic [1:0] POL_SMALLEST = 2'd3;

  localparam logic [1:0] REG_ITER   = 2'd0;
  localparam logic [1:0] REG_POLICY = 2'd1;
  localparam logic [1:0] REG_WOR    = 2'd2;
  localparam logic [1:0] REG_SEED   = 2'd3;

  localparam logic OP_ARRIVAL  = 1'b0;
  localparam logic OP_SCHEDULE = 1'b1;

  typedef struct packed {
    logic              op;
    logic [PORT_W-1:0] src_port;
    logic [PORT_W-1:0] dst_port;
  } in_item_t;

  typedef struct packed {
    logic [PORT_W-1:0] in_port;
    logic [PORT_W-1:0] out_port;
    logic              matched;
    logic              last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic arrive;       // apply arrival to the count store
    logic slot_init;    // clear match state for a new slot
    logic iter_init;    // clear proposals, draw start index
    logic sum_clear;    // clear running-sum accumulator
    logic sum_step;     // accumulate one leaf into the total
    logic draw;         // advance lfsr, compute sample point
    logic scan_clear;
    logic scan_step;    // walk one leaf of the running sum
    logic propose;      // record proposal and run the accept rule
    logic next_input;
    logic commit_step;  // commit one output's kept proposer
    logic final_read;   // read the matched queue of the current result row
    logic final_step;   // decrement one matched queue, emit one result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_matched;   // current input already matched
    logic total_zero;
    logic scan_hit;
    logic leaf_last;    // leaf counter at last port
    logic port_last;    // port walk at last element
    logic result_busy;  // output register still holds a result
  } dp_stat_t;

endpackage

// ----- hdl/qps_switch_scheduler_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qps_switch_scheduler_top
// input-queued crossbar scheduler with queue-proportional sampling
// ----------------------------------------------------------------------------
// arrival: read-modify-write on the count store (arrive state, then write state)
// schedule: an accept step, then per iteration a leaf walk over the count store
//   for each unmatched input (sum, then sampling scan) and a commit walk over
//   the outputs; results drain through a read state and an emit state per port
// one item in flight at a time; results leave through an output register
// synchronous reset clears counts (valid bits), matches, config and lfsr
module qps_switch_scheduler_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  qps_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output qps_pkg::out_item_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import qps_pkg::*;

  logic [3:0]  iteration_count;
  logic [1:0]  keep_rule;
  logic        hide_losers;
  logic [31:0] random_seed;
  logic        wr;
  logic [1:0]  ridx;
  in_item_t    held;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign ridx   = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_count <= 4'd1;
      keep_rule       <= POL_EARLIEST;
      hide_losers     <= 1'b0;
      random_seed     <= 32'd1;
    end else if (wr) begin
      case (ridx)
        REG_ITER:   iteration_count <= pwdata[3:0];
        REG_POLICY: keep_rule       <= pwdata[1:0];
        REG_WOR:    hide_losers     <= pwdata[0];
        REG_SEED:   random_seed     <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_ITER:   prdata = {28'd0, iteration_count};
      REG_POLICY: prdata = {30'd0, keep_rule};
      REG_WOR:    prdata = {31'd0, hide_losers};
      REG_SEED:   prdata = random_seed;
      default:    prdata = '0;
    endcase
  end

  // hold the accepted item for the arrival read-modify-write
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) held <= in_data;
  end

  qps_controller u_ctrl (
    .clk, .rst, .in_valid, .in_ready,
    .op(in_data.op), .iteration_count, .cmd, .stat
  );

  qps_datapath u_dp (
    .clk, .rst, .cmd, .stat,
    .item(in_ready ? in_data : held),
    .cfg_seed_we(wr && ridx == REG_SEED), .cfg_seed(pwdata),
    .keep_rule, .hide_losers,
    .result(out_data), .result_valid(out_valid), .result_ready(out_ready)
  );

endmodule

// ----- hdl/qps_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qps_datapath
// count store, match tables, lfsr, sampling arithmetic and result register
// ----------------------------------------------------------------------------
module qps_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  qps_pkg::dp_cmd_t     cmd,
  output qps_pkg::dp_stat_t    stat,
  input  qps_pkg::in_item_t    item,
  input  logic                 cfg_seed_we,
  input  logic [31:0]          cfg_seed,
  input  logic [1:0]           keep_rule,
  input  logic                 hide_losers,
  output qps_pkg::out_item_t   result,
  output logic                 result_valid,
  input  logic                 result_ready
);
  import qps_pkg::*;

  localparam int ADDR_W = 2 * PORT_W;

  // count store as memory: one read port and one write port, registered read
  logic [COUNT_WIDTH-1:0] mem [NUM_PORTS*NUM_PORTS];
  logic [NUM_PORTS*NUM_PORTS-1:0] valid_bits;
  logic [ADDR_W-1:0] rd_addr;
  logic [COUNT_WIDTH-1:0] rd_raw;
  logic rd_valid;
  logic [COUNT_WIDTH-1:0] rd_data;

  logic [31:0] lfsr;
  logic [PORT_W-1:0] in_cur;     // current input
  logic [PORT_W-1:0] cnt;        // port walk counter
  logic [PORT_W-1:0] leaf;       // leaf counter
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] acc;
  logic [TOTAL_W-1:0] r_pt;
  logic [PORT_W-1:0] sampled;
  logic [COUNT_WIDTH-1:0] samp_len;  // queue length of the sampled leaf
  logic              hit;
  logic [NUM_PORTS-1:0] in_m, out_m;
  logic [PORT_W-1:0] in_to [NUM_PORTS];
  logic [NUM_PORTS-1:0] acc_v;
  logic [PORT_W-1:0] acc_in [NUM_PORTS];
  logic [COUNT_WIDTH-1:0] acc_len [NUM_PORTS];
  logic [NUM_PORTS-1:0] prop_v;
  logic [PORT_W-1:0] prop_o [NUM_PORTS];
  logic [NUM_PORTS-1:0] hidden [NUM_PORTS];
  logic [31:0] lfsr_adv;
  logic [31:0] seed_fix;
  logic [PORT_W-1:0] leaf_sel;
  logic [COUNT_WIDTH-1:0] wgt;
  logic [TOTAL_W-1:0] acc_sum;
  logic [31+TOTAL_W:0] prod;
  logic [COUNT_WIDTH-1:0] arr_val;
  logic take;
  logic [PORT_W-1:0] pin;
  logic [PORT_W-1:0] mo;
  logic [PORT_W-1:0] cur_in;

  assign lfsr_adv = lfsr[0] ? ((lfsr >> 1) ^ LFSR_MASK) : (lfsr >> 1);
  assign seed_fix = (cfg_seed == 32'd0) ? 32'd1 : cfg_seed;
  assign prod     = lfsr_adv * total;
  assign rd_data  = rd_valid ? rd_raw : '0;
  assign cur_in   = in_cur + cnt;

  // address for the next registered read
  always_comb begin
    leaf_sel = leaf;
    rd_addr = {item.src_port, item.dst_port};
    if (cmd.sum_clear || cmd.scan_clear) leaf_sel = '0;
    else if (cmd.sum_step || cmd.scan_step) leaf_sel = leaf + PORT_W'(1);
    if (cmd.sum_clear || cmd.sum_step || cmd.scan_clear || cmd.scan_step)
      rd_addr = {cur_in, leaf_sel};
    else if (cmd.propose || cmd.next_input)
      rd_addr = {cur_in, sampled};
    else if (cmd.final_read || cmd.slot_init)
      rd_addr = {cnt, in_to[cnt]};
  end

  assign wgt     = hidden[cur_in][leaf] ? '0 : rd_data;
  assign acc_sum = acc + TOTAL_W'(wgt);
  assign arr_val = (rd_data == COUNT_MAX) ? rd_data : rd_data + COUNT_WIDTH'(1);

  always_ff @(posedge clk) begin
    rd_raw   <= mem[rd_addr];
    rd_valid <= valid_bits[rd_addr];
  end

  // accept rule
  always_comb begin
    take = 1'b0;
    mo = sampled;
    if (!acc_v[mo]) take = 1'b1;
    else begin
      case (keep_rule)
        POL_LONGEST:  take = samp_len > acc_len[mo];
        POL_SHORTEST: take = samp_len < acc_len[mo];
        POL_SMALLEST: take = cur_in < acc_in[mo];
        default:      take = 1'b0;
      endcase
    end
    pin = acc_in[cnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits   <= '0;
      lfsr         <= 32'd1;
      result_valid <= 1'b0;
      in_m         <= '0;
      out_m        <= '0;
    end else begin
      if (cfg_seed_we) lfsr <= seed_fix;
      if (result_valid && result_ready && !cmd.final_step) result_valid <= 1'b0;

      if (cmd.arrive) begin
        mem[{item.src_port, item.dst_port}] <= arr_val;
        valid_bits[{item.src_port, item.dst_port}] <= 1'b1;
      end

      if (cmd.slot_init) begin
        in_m <= '0;
        out_m <= '0;
        cnt <= '0;
        for (int i = 0; i < NUM_PORTS; i++) hidden[i] <= '0;
      end

      if (cmd.iter_init) begin
        lfsr <= lfsr_adv;
        in_cur <= PORT_W'(({32'd0, lfsr_adv} * 64'(NUM_PORTS)) >> 32);
        cnt <= '0;
        acc_v <= '0;
        prop_v <= '0;
      end

      if (cmd.sum_clear) begin
        leaf <= '0;
        total <= '0;
        acc <= '0;
      end
      if (cmd.sum_step) begin
        total <= acc_sum;
        acc <= acc_sum;
        leaf <= leaf_sel;
      end

      if (cmd.draw) begin
        lfsr <= lfsr_adv;
        r_pt <= TOTAL_W'(prod >> 32);
      end

      if (cmd.scan_clear) begin
        leaf <= '0;
        acc <= '0;
        hit <= 1'b0;
      end
      if (cmd.scan_step) begin
        acc <= acc_sum;
        leaf <= leaf_sel;
        if (!hit && acc_sum > r_pt) begin
          hit <= 1'b1;
          sampled <= leaf;
          samp_len <= rd_data;
        end else if (!hit) begin
          sampled <= leaf;
          samp_len <= rd_data;
        end
      end

      if (cmd.propose) begin
        prop_v[cur_in] <= 1'b1;
        prop_o[cur_in] <= sampled;
        if (!out_m[sampled] && take) begin
          acc_v[sampled]   <= 1'b1;
          acc_in[sampled]  <= cur_in;
          acc_len[sampled] <= samp_len;
        end
      end

      if (cmd.next_input) cnt <= cnt + PORT_W'(1);

      if (cmd.commit_step) begin
        cnt <= cnt + PORT_W'(1);
        if (acc_v[cnt] && !in_m[pin]) begin
          out_m[cnt] <= 1'b1;
          in_m[pin] <= 1'b1;
          in_to[pin] <= cnt;
        end
        if (cnt == PORT_W'(NUM_PORTS - 1) && hide_losers) begin
          for (int i = 0; i < NUM_PORTS; i++)
            if (prop_v[i] && !(in_m[i] || (acc_v[cnt] && pin == PORT_W'(i))))
              hidden[i][prop_o[i]] <= 1'b1;
        end
      end

      if (cmd.final_step) begin
        if (in_m[cnt] && rd_data != '0) mem[{cnt, in_to[cnt]}] <= rd_data - COUNT_WIDTH'(1);
        result.in_port  <= cnt;
        result.out_port <= in_m[cnt] ? in_to[cnt] : '0;
        result.matched  <= in_m[cnt];
        result.last     <= cnt == PORT_W'(NUM_PORTS - 1);
        result_valid    <= 1'b1;
        cnt <= cnt + PORT_W'(1);
      end
    end
  end

  assign stat.in_matched  = in_m[cur_in];
  assign stat.total_zero  = total == '0;
  assign stat.scan_hit    = hit;
  assign stat.leaf_last   = leaf == PORT_W'(NUM_PORTS - 1);
  assign stat.port_last   = cnt == PORT_W'(NUM_PORTS - 1);
  assign stat.result_busy = result_valid && !result_ready;

endmodule

// ----- hdl/qps_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qps_controller
// sequencer for arrivals, propose/accept iterations and result drain
// ----------------------------------------------------------------------------
module qps_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [3:0]         iteration_count,
  output qps_pkg::dp_cmd_t   cmd,
  input  qps_pkg::dp_stat_t  stat
);
  import qps_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_ARRIVE = 12'b000000000010,
    S_WRITE  = 12'b000000000100,
    S_ITER   = 12'b000000001000,
    S_CHECK  = 12'b000000010000,
    S_SUM    = 12'b000000100000,
    S_DRAW   = 12'b000001000000,
    S_SCAN   = 12'b000010000000,
    S_PROP   = 12'b000100000000,
    S_COMMIT = 12'b001000000000,
    S_FINAL  = 12'b010000000000,
    S_EMIT   = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic [3:0] iters, iters_next, it, it_next;
  logic [3:0] lim;

  assign lim = (iteration_count == 4'd0) ? 4'd1 :
               (iteration_count > 4'(MAX_ITERATIONS)) ? 4'(MAX_ITERATIONS) : iteration_count;
  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    iters_next = iters;
    it_next = it;
    cmd = '0;
    case (state)
      S_IDLE: if (in_valid) begin
        if (op == OP_SCHEDULE) begin
          cmd.slot_init = 1'b1;
          iters_next = lim;
          it_next = '0;
          state_next = S_ITER;
        end else state_next = S_ARRIVE;
      end
      S_ARRIVE: state_next = S_WRITE;   // read latency of the count store
      S_WRITE: begin
        cmd.arrive = 1'b1;
        state_next = S_IDLE;
      end
      S_ITER: begin
        cmd.iter_init = 1'b1;
        state_next = S_CHECK;
      end
      // the port counter wraps to zero on the way into the commit walk
      S_CHECK: begin
        if (stat.in_matched) begin
          if (stat.port_last) state_next = S_COMMIT;
          cmd.next_input = 1'b1;
        end else begin
          cmd.sum_clear = 1'b1;
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (stat.leaf_last) begin
          cmd.sum_step = 1'b1;
          state_next = S_DRAW;
        end
      end
      S_DRAW: begin
        if (stat.total_zero) begin
          cmd.next_input = 1'b1;
          if (stat.port_last) state_next = S_COMMIT;
          else state_next = S_CHECK;
        end else begin
          cmd.draw = 1'b1;
          cmd.scan_clear = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.leaf_last) begin
          cmd.scan_step = 1'b1;
          cmd.propose = 1'b0;
          state_next = S_PROP;
        end
      end
      S_PROP: begin
        cmd.propose = 1'b1;
        cmd.next_input = 1'b1;
        if (stat.port_last) state_next = S_COMMIT;
        else state_next = S_CHECK;
      end
      S_COMMIT: begin
        cmd.commit_step = 1'b1;
        if (stat.port_last) begin
          it_next = it + 4'd1;
          if (it + 4'd1 == iters) begin
            cmd.slot_init = 1'b0;
            state_next = S_FINAL;
          end else state_next = S_ITER;
        end
      end
      S_FINAL: begin
        cmd.final_read = 1'b1;
        state_next = S_EMIT;            // read latency
      end
      S_EMIT: if (!stat.result_busy) begin
        cmd.final_step = 1'b1;
        state_next = stat.port_last ? S_IDLE : S_FINAL;
      end else begin
        cmd.final_read = 1'b1;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iters <= 4'd1;
      it    <= '0;
    end else begin
      state <= state_next;
      iters <= iters_next;
      it    <= it_next;
    end
  end

endmodule
